@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL.
// Clock and reset names are taken from the module that uses them: clk, rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

@@ rtl/core/alpir_pkg.sv @@
// Types and constants for the positional insert/remove list.
// No dependencies.
`timescale 1ns / 1ps

package alpir_pkg;

    localparam int CAPACITY    = 128;
    localparam int ENTRY_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int POS_W       = 8;
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [2:0] OP_INS_POS   = 3'd0;
    localparam logic [2:0] OP_INS_FRONT = 3'd1;
    localparam logic [2:0] OP_INS_END   = 3'd2;
    localparam logic [2:0] OP_REM_POS   = 3'd3;
    localparam logic [2:0] OP_REM_FRONT = 3'd4;
    localparam logic [2:0] OP_REM_END   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [2:0]       operation;
        logic [POS_W-1:0] position;
        logic [31:0]      entry_value;
    } req_word_t;

    typedef struct packed {
        logic [31:0] removed_value;
        logic [1:0]  status;
        logic [7:0]  entry_count;
    } rsp_word_t;

endpackage

@@ rtl/core/array_list_positional_insert_remove.sv @@
// Fixed-capacity ordered list with positional insert and remove.
// Depends on alpir_pkg and assert_macros.svh.
//
//  channel | valid     | ready     | word
//  --------+-----------+-----------+------------------------------------------
//  request | req_valid | req_ready | req: operation, position, entry_value
//  result  | rsp_valid | rsp_ready | rsp: removed_value, status, entry_count
//
// A successful remove, or an insert below the end, at index p with n entries
// held moves the n - p entries from p on through the shift loop over the single
// list RAM, one read and one write per cycle, before its result loads; an insert
// at the end writes its word alone; errors and unused codes skip the loop. The
// next request is taken the cycle after the result loads, even while that word
// still waits. Reset clears count and control, not the RAM.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module array_list_positional_insert_remove (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  alpir_pkg::req_word_t req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output alpir_pkg::rsp_word_t rsp
);
    import alpir_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_FIN} state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   ins_reg;
    logic [IDX_W-1:0]       at_reg;
    logic [ENTRY_WIDTH-1:0] val_reg;
    logic [ENTRY_WIDTH-1:0] got_reg;
    logic [1:0]             status_reg;
    logic [CNT_W-1:0]       rd_left_reg;
    logic [IDX_W-1:0]       rd_addr_reg;
    logic                   rd_pend_reg;
    logic [IDX_W-1:0]       pend_addr_reg;
    logic                   rsp_valid_reg;
    rsp_word_t              rsp_reg;

    logic [ENTRY_WIDTH-1:0] mem [CAPACITY];
    logic [ENTRY_WIDTH-1:0] mem_q;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [ENTRY_WIDTH-1:0] mem_wdata;
    logic                   rd_en;

    logic                   req_fire;
    logic                   dec_ins;
    logic                   dec_rem;
    logic [CMP_W-1:0]       dec_at;
    logic [CMP_W-1:0]       cnt_ext;
    logic [1:0]             dec_status;
    logic                   dec_go;
    logic [CNT_W-1:0]       dec_count_next;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cnt_ext   = CMP_W'(count_reg);

    // request decode against the current count
    always_comb
    begin
        dec_ins    = 1'b0;
        dec_rem    = 1'b0;
        dec_at     = '0;
        dec_status = ST_OK;
        unique case (req.operation)
            OP_INS_POS:
            begin
                dec_ins = 1'b1;
                dec_at  = CMP_W'(req.position);
            end
            OP_INS_FRONT: dec_ins = 1'b1;
            OP_INS_END:
            begin
                dec_ins = 1'b1;
                dec_at  = cnt_ext;
            end
            OP_REM_POS:
            begin
                dec_rem = 1'b1;
                dec_at  = CMP_W'(req.position);
            end
            OP_REM_FRONT: dec_rem = 1'b1;
            OP_REM_END:
            begin
                dec_rem = 1'b1;
                dec_at  = cnt_ext - CMP_W'(1);
            end
            default: ;
        endcase
        if (dec_ins)
        begin
            if (count_reg == CNT_W'(CAPACITY))
                dec_status = ST_FULL;
            else if (dec_at > cnt_ext)
                dec_status = ST_RANGE;
        end
        else if (dec_rem)
        begin
            if (count_reg == '0)
                dec_status = ST_EMPTY;
            else if (dec_at >= cnt_ext)
                dec_status = ST_RANGE;
        end
        dec_go = (dec_status == ST_OK) && (dec_ins || dec_rem);
        if (dec_go && dec_ins)
            dec_count_next = count_reg + CNT_W'(1);
        else if (dec_go)
            dec_count_next = count_reg - CNT_W'(1);
        else
            dec_count_next = count_reg;
    end

    // RAM port control: each shift write lands in the cycle after its read
    always_comb
    begin
        rd_en     = (state_reg == S_SHIFT) && (rd_left_reg != '0);
        mem_we    = 1'b0;
        mem_waddr = pend_addr_reg;
        mem_wdata = mem_q;
        if (state_reg == S_SHIFT)
        begin
            if (rd_pend_reg)
            begin
                if (ins_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg + IDX_W'(1);
                end
                else if (pend_addr_reg != at_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg - IDX_W'(1);
                end
            end
            else if (rd_left_reg == '0 && ins_reg)
            begin
                // gap is open, drop the new word in
                mem_we    = 1'b1;
                mem_waddr = at_reg;
                mem_wdata = val_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            mem_q <= mem[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ins_reg       <= 1'b0;
            at_reg        <= '0;
            val_reg       <= '0;
            got_reg       <= '0;
            status_reg    <= ST_OK;
            rd_left_reg   <= '0;
            rd_addr_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            pend_addr_reg <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            // in S_FIN the load below decides the valid flag
            if (rsp_ready && state_reg != S_FIN)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        ins_reg     <= dec_ins;
                        at_reg      <= IDX_W'(dec_at);
                        val_reg     <= ENTRY_WIDTH'(req.entry_value);
                        got_reg     <= '0;
                        status_reg  <= dec_status;
                        count_reg   <= dec_count_next;
                        rd_left_reg <= CNT_W'(cnt_ext - dec_at);
                        rd_addr_reg <= dec_ins ? IDX_W'(cnt_ext - CMP_W'(1))
                                               : IDX_W'(dec_at);
                        rd_pend_reg <= 1'b0;
                        state_reg   <= dec_go ? S_SHIFT : S_FIN;
                    end
                end
                S_SHIFT:
                begin
                    rd_pend_reg   <= rd_en;
                    pend_addr_reg <= rd_addr_reg;
                    if (rd_en)
                    begin
                        rd_left_reg <= rd_left_reg - CNT_W'(1);
                        rd_addr_reg <= ins_reg ? rd_addr_reg - IDX_W'(1)
                                               : rd_addr_reg + IDX_W'(1);
                    end
                    if (rd_pend_reg && !ins_reg && pend_addr_reg == at_reg)
                        got_reg <= mem_q;
                    if (!rd_en && !rd_pend_reg)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_valid_reg         <= 1'b1;
                        rsp_reg.removed_value <= 32'(got_reg);
                        rsp_reg.status        <= status_reg;
                        rsp_reg.entry_count   <= 8'(count_reg);
                        state_reg             <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEVER(a_count_bound, count_reg > CNT_W'(CAPACITY), "count above capacity")
    `ASSERT_CLK(a_ins_count,
        (req_fire && dec_go && dec_ins) |=> (count_reg == $past(count_reg) + CNT_W'(1)),
        "insert did not bump count")
    `ASSERT_NEVER(a_err_zero,
        rsp_valid && rsp.status != ST_OK && rsp.removed_value != '0,
        "error word carries data")
    `ASSERT_CLK(a_pend_shift, rd_pend_reg |-> (state_reg == S_SHIFT), "read data outside shift")

endmodule

@@ test/tb_array_list_positional_insert_remove.sv @@
// Self-checking testbench for array_list_positional_insert_remove: directed table, then
// phased random insert/remove traffic with idling, checked against table or in-bench list model.
// Depends on alpir_pkg and the DUT; reads no files.
`timescale 1ns / 1ps

module tb_array_list_positional_insert_remove;
    import alpir_pkg::*;

    // Operation codes the block treats as no-ops
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = CAPACITY + 8;

    typedef struct {
        req_word_t w;
        bit        typed;
        rsp_word_t exp;
    } dir_row_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    req_word_t req       = '0;
    logic      rsp_ready = 1'b0;
    logic      req_ready;
    logic      rsp_valid;
    rsp_word_t rsp;

    // list model
    logic [ENTRY_WIDTH-1:0] list_image [CAPACITY];
    int                     list_len = 0;
    int                     deepest  = 0;

    rsp_word_t pending_results [$];
    dir_row_t  dir_rows [$];

    int n_errors  = 0;
    int n_checked = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int stall_pct = 0;
    int idle_pct  = 0;
    bit holdoff_req  = 1'b0;
    int holdoff_left = 0;

    // first phase inserts only, apart from spare codes, so the list runs full
    int ph_items  [4] = '{150, 130, 130, 110};
    int ph_ins    [4] = '{100, 15, 60, 35};
    int ph_idle   [4] = '{0, 47, 0, 26};
    int ph_stall  [4] = '{0, 0, 47, 26};

    array_list_positional_insert_remove uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #8ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [1:0] list_insert(int at, logic [ENTRY_WIDTH-1:0] v);
        int i;
        if (list_len >= CAPACITY)
            return ST_FULL;
        if (at > list_len)
            return ST_RANGE;
        for (i = list_len; i > at; i--)
            list_image[i] = list_image[i-1];
        list_image[at] = v;
        list_len++;
        if (list_len > deepest)
            deepest = list_len;
        return ST_OK;
    endfunction

    function automatic logic [1:0] list_remove(int at, output logic [ENTRY_WIDTH-1:0] got);
        int i;
        got = '0;
        if (list_len == 0)
            return ST_EMPTY;
        if (at >= list_len)
            return ST_RANGE;
        got = list_image[at];
        list_len--;
        // only entries above the removed one move down
        for (i = at; i < list_len; i++)
            list_image[i] = list_image[i+1];
        return ST_OK;
    endfunction

    function automatic rsp_word_t apply_list_op(req_word_t w);
        rsp_word_t              r;
        logic [1:0]             st;
        logic [ENTRY_WIDTH-1:0] got;
        got = '0;
        st  = ST_OK;
        case (w.operation)
            OP_INS_POS:   st = list_insert(int'(w.position), w.entry_value);
            OP_INS_FRONT: st = list_insert(0, w.entry_value);
            OP_INS_END:   st = list_insert(list_len, w.entry_value);
            OP_REM_POS:   st = list_remove(int'(w.position), got);
            OP_REM_FRONT: st = list_remove(0, got);
            OP_REM_END:   st = (list_len == 0) ? ST_EMPTY : list_remove(list_len - 1, got);
            default:      st = ST_OK;
        endcase
        r.removed_value = (st == ST_OK) ? got : '0;
        r.status        = st;
        r.entry_count   = list_len[7:0];
        return r;
    endfunction

    function automatic dir_row_t mk_row(logic [2:0] op, logic [7:0] pos, logic [31:0] val,
                                        bit typed, logic [31:0] rv, logic [1:0] st,
                                        logic [7:0] cnt);
        dir_row_t row;
        row.w.operation       = op;
        row.w.position        = pos;
        row.w.entry_value     = val;
        row.typed             = typed;
        row.exp.removed_value = rv;
        row.exp.status        = st;
        row.exp.entry_count   = cnt;
        return row;
    endfunction

    // random word; positions mostly legal against the current count, some noise
    function automatic req_word_t make_word(int ins_pct);
        req_word_t w;
        int        kind;
        w.entry_value = $urandom;
        w.position    = 8'($urandom_range(255));
        if ($urandom_range(99) < 3)
        begin
            w.operation = ($urandom_range(1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
        end
        else if ($urandom_range(99) < ins_pct)
        begin
            kind = $urandom_range(2);
            w.operation = (kind == 0) ? OP_INS_POS : (kind == 1) ? OP_INS_FRONT : OP_INS_END;
            if (w.operation == OP_INS_POS && $urandom_range(9) != 0)
                w.position = 8'($urandom_range(list_len));
        end
        else
        begin
            kind = $urandom_range(2);
            w.operation = (kind == 0) ? OP_REM_POS : (kind == 1) ? OP_REM_FRONT : OP_REM_END;
            if (w.operation == OP_REM_POS && $urandom_range(9) != 0 && list_len > 0)
                w.position = 8'($urandom_range(list_len - 1));
        end
        return w;
    endfunction

    task automatic send_word(req_word_t w, bit typed, rsp_word_t typed_exp);
        rsp_word_t pred;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        req       <= w;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        pred = apply_list_op(w);
        pending_results.push_back(typed ? typed_exp : pred);
    endtask

    task automatic wait_all_results();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_result(rsp_word_t got);
        rsp_word_t want;
        if (pending_results.size() == 0)
        begin
            $error("result word with nothing expected: %h", got);
            n_errors++;
        end
        else
        begin
            want = pending_results.pop_front();
            n_checked++;
            status_seen[got.status]++;
            if (got.removed_value !== want.removed_value)
            begin
                $error("removed_value: expected %h, got %h", want.removed_value,
                       got.removed_value);
                n_errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                n_errors++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", want.entry_count,
                       got.entry_count);
                n_errors++;
            end
        end
    endtask

    // result side: check, then pick ready for the next cycle
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                check_result(rsp);
            if (holdoff_req)
            begin
                holdoff_req  = 1'b0;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0)
            begin
                rsp_ready <= 1'b0;
                holdoff_left--;
            end
            else
                rsp_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        int p;
        int k;
        dir_row_t row;

        for (k = 0; k < CAPACITY; k++)
            list_image[k] = '0;

        // empty-list checks come before position checks
        dir_rows.push_back(mk_row(OP_REM_FRONT, 8'd0,   32'h1111_1111, 1'b1, '0, ST_EMPTY, 8'd0));
        dir_rows.push_back(mk_row(OP_REM_END,   8'd0,   32'h0,         1'b1, '0, ST_EMPTY, 8'd0));
        dir_rows.push_back(mk_row(OP_REM_POS,   8'd0,   32'h0,         1'b1, '0, ST_EMPTY, 8'd0));
        dir_rows.push_back(mk_row(OP_REM_POS,   8'd255, 32'hFFFF_FFFF, 1'b1, '0, ST_EMPTY, 8'd0));
        dir_rows.push_back(mk_row(OP_INS_POS,   8'd1,   32'hDEAD_BEEF, 1'b1, '0, ST_RANGE, 8'd0));
        dir_rows.push_back(mk_row(OP_INS_POS,   8'd0,   32'hFFFF_FFFF, 1'b1, '0, ST_OK,    8'd1));
        dir_rows.push_back(mk_row(OP_INS_FRONT, 8'd255, 32'h0000_0000, 1'b1, '0, ST_OK,    8'd2));
        dir_rows.push_back(mk_row(OP_INS_END,   8'd77,  32'hA5A5_A5A5, 1'b1, '0, ST_OK,    8'd3));
        dir_rows.push_back(mk_row(OP_INS_POS,   8'd3,   32'h5A5A_5A5A, 1'b1, '0, ST_OK,    8'd4));
        dir_rows.push_back(mk_row(OP_INS_POS,   8'd2,   32'h1234_5678, 1'b0, '0, ST_OK,    8'd0));
        dir_rows.push_back(mk_row(OP_INS_POS,   8'd255, 32'h0BAD_F00D, 1'b1, '0, ST_RANGE, 8'd5));
        dir_rows.push_back(mk_row(OP_INS_POS,   8'd6,   32'h0BAD_F00D, 1'b1, '0, ST_RANGE, 8'd5));
        dir_rows.push_back(mk_row(OP_SPARE_6,   8'd0,   32'h0,         1'b1, '0, ST_OK,    8'd5));
        dir_rows.push_back(mk_row(OP_SPARE_7,   8'd255, 32'hFFFF_FFFF, 1'b1, '0, ST_OK,    8'd5));
        dir_rows.push_back(mk_row(OP_REM_POS,   8'd5,   32'h0,         1'b1, '0, ST_RANGE, 8'd5));
        dir_rows.push_back(mk_row(OP_REM_POS,   8'd255, 32'h0,         1'b1, '0, ST_RANGE, 8'd5));
        // middle removal must shift only the upper entries
        dir_rows.push_back(mk_row(OP_REM_POS,   8'd2,   32'h0,         1'b0, '0, ST_OK,    8'd0));
        dir_rows.push_back(mk_row(OP_REM_POS,   8'd0,   32'h0,         1'b0, '0, ST_OK,    8'd0));
        dir_rows.push_back(mk_row(OP_REM_FRONT, 8'd128, 32'h0,         1'b0, '0, ST_OK,    8'd0));
        dir_rows.push_back(mk_row(OP_REM_END,   8'd1,   32'h0,         1'b0, '0, ST_OK,    8'd0));
        dir_rows.push_back(mk_row(OP_REM_END,   8'd0,   32'h0,         1'b0, '0, ST_OK,    8'd0));
        dir_rows.push_back(mk_row(OP_REM_END,   8'd0,   32'h0,         1'b1, '0, ST_EMPTY, 8'd0));

        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_word(row.w, row.typed, row.exp);
        end
        wait_all_results();

        for (p = 0; p < 4; p++)
        begin
            idle_pct  = ph_idle[p];
            stall_pct = ph_stall[p];
            // receiver holds off long enough that the input stalls
            if (p == 2)
                holdoff_req = 1'b1;
            for (k = 0; k < ph_items[p]; k++)
                send_word(make_word(ph_ins[p]), 1'b0, '0);
            wait_all_results();
        end

        // catch stray words after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d result words; ok %0d, full %0d, empty %0d, range %0d",
                 n_checked, status_seen[ST_OK], status_seen[ST_FULL],
                 status_seen[ST_EMPTY], status_seen[ST_RANGE]);
        $display("list reached %0d of %0d entries", deepest, CAPACITY);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/alpir_pkg.sv
rtl/core/array_list_positional_insert_remove.sv
test/tb_array_list_positional_insert_remove.sv
